// ===== rtl/pixel_blend_four_mode_assert.svh =====
// Assertion macros used by the blender's control module.
`ifndef PIXEL_BLEND_FOUR_MODE_ASSERT_SVH
`define PIXEL_BLEND_FOUR_MODE_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define PBFM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also runs during reset.
`define PBFM_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pbfm_pkg.sv =====
`default_nettype none

package pbfm_pkg;

    // Number of register stages from input to output.
    localparam int NSTG = 5;

    localparam logic [8:0]  W_ONE     = 9'd256;
    localparam logic [15:0] ALPHA_DEN = 16'd65280;
    localparam logic [7:0]  CH_MAX    = 8'd255;
    localparam logic [15:0] SQ_MAX    = 16'd65025;
    // ceil(2^23 / 255); exact floor(x / 255) for any 16-bit x.
    localparam logic [15:0] RECIP_255 = 16'd32897;

    typedef enum logic [1:0] {
        MODE_ALPHA  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_MUL    = 2'd2,
        MODE_SCREEN = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_MODE   = 1'b0,
        CFG_WEIGHT = 1'b1
    } t_cfg_idx;

    // Per-stage load enables and valid flags of the pipeline.
    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] vld;
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/pbfm_ctrl.sv =====
`default_nettype none
`include "pixel_blend_four_mode_assert.svh"

module pbfm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_vld,
    input  wire logic          i_out_rdy,
    output logic               o_in_rdy,
    output pbfm_pkg::t_ctl     o_ctl
);
    import pbfm_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] vld_in;
    logic            acc_in;
    logic            acc_out;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        rdy[NSTG] = i_out_rdy;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        vld_in = {r_vld[NSTG-2:0], i_in_vld};
        n_vld  = (rdy[NSTG-1:0] & vld_in) | (~rdy[NSTG-1:0] & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // No input transaction is taken while reset is held.
    assign o_in_rdy  = rdy[0] && i_rst_n;
    assign o_ctl.en  = rdy[NSTG-1:0];
    assign o_ctl.vld = r_vld;
    assign acc_in    = i_in_vld && o_in_rdy;
    assign acc_out   = r_vld[NSTG-1] && i_out_rdy;

    `PBFM_ASSERT_RST(a_rst_clear, i_clk, !i_rst_n |=> (r_vld == '0), "valid flags survive reset")
    `PBFM_ASSERT(a_count, i_clk, i_rst_n, 1'b1 |=> ($countones(r_vld) == $past($countones(r_vld)) + $past(acc_in) - $past(acc_out)), "pixel lost or duplicated in pipeline")
    `PBFM_ASSERT(a_no_overwrite, i_clk, i_rst_n, ((r_vld[NSTG-2:0] & rdy[NSTG-2:0] & r_vld[NSTG-1:1] & ~rdy[NSTG-1:1]) == '0), "stage overwrites a stalled stage")
    `PBFM_ASSERT(a_ready_free, i_clk, i_rst_n, (r_vld != '1) |-> rdy[0], "input stalled while pipeline has room")

endmodule

`default_nettype wire

// ===== rtl/pbfm_chan.sv =====
`default_nettype none

module pbfm_chan (
    input  wire logic            i_clk,
    input  wire pbfm_pkg::t_ctl  i_ctl,
    input  wire pbfm_pkg::t_mode i_mode,
    input  wire logic [8:0]      i_w,
    input  wire logic [15:0]     i_ws,
    input  wire logic [7:0]      i_d,
    input  wire logic [7:0]      i_s,
    output logic [7:0]           o_ch
);
    import pbfm_pkg::*;

    logic [7:0]  ax;
    logic [15:0] ay;
    logic [15:0] by;
    logic [23:0] sum;
    logic [8:0]  addsum;
    logic [15:0] x;
    logic [7:0]  add;

    logic [23:0] r_pa;
    logic [23:0] r_pb;
    t_mode       r_mode2;
    logic [15:0] r_x3;
    logic        r_byp3;
    logic [7:0]  r_add3;
    logic [30:0] r_q4;
    logic        r_byp4;
    logic [7:0]  r_add4;
    logic [7:0]  r_ch5;

    // Operand selection: one general product and one weighted source product.
    always_comb begin
        unique case (i_mode)
            MODE_ALPHA: begin
                ax = i_d;
                ay = ALPHA_DEN - i_ws;
                by = i_ws;
            end
            MODE_ADD: begin
                ax = i_d;
                ay = 16'd1;
                by = {7'd0, i_w};
            end
            MODE_MUL: begin
                ax = i_d;
                ay = {8'd0, i_s};
                by = '0;
            end
            MODE_SCREEN: begin
                ax = CH_MAX - i_d;
                ay = {8'd0, CH_MAX - i_s};
                by = '0;
            end
            default: begin
                ax = '0;
                ay = '0;
                by = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_pa    <= {16'd0, ax} * {8'd0, ay};
            r_pb    <= {16'd0, i_s} * {8'd0, by};
            r_mode2 <= i_mode;
        end
    end

    // Reduce to a 16-bit dividend for the shared divide by 255, except
    // additive mode, which finishes here with a saturating add.
    always_comb begin
        sum    = r_pa + r_pb;
        addsum = {1'b0, r_pa[7:0]} + r_pb[16:8];
        add    = addsum[8] ? CH_MAX : addsum[7:0];
        unique case (r_mode2)
            MODE_ALPHA:  x = sum[23:8];
            MODE_ADD:    x = '0;
            MODE_MUL:    x = r_pa[15:0];
            MODE_SCREEN: x = SQ_MAX - r_pa[15:0];
            default:     x = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_x3   <= x;
            r_byp3 <= (r_mode2 == MODE_ADD);
            r_add3 <= add;
        end
    end

    // The dividend never exceeds 65025, so the product fits in 31 bits.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_q4   <= 31'({16'd0, r_x3} * {16'd0, RECIP_255});
            r_byp4 <= r_byp3;
            r_add4 <= r_add3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_ch5 <= r_byp4 ? r_add4 : r_q4[30:23];
        end
    end

    assign o_ch = r_ch5;

endmodule

`default_nettype wire

// ===== rtl/pixel_blend_four_mode.sv =====
// An accepted input transaction passes through the five stages to the output.
// Throughput: one pixel per clock unless the output stalls; one register per stage.
// A stalled output holds its stage, and earlier stages keep filling any empty slots.
// Reset (synchronous, active low) empties the pipeline, sets alpha mode and
// a weight of 1.0 (256).
`default_nettype none

module pixel_blend_four_mode (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port: index 0 blend mode, index 1 weight.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [8:0]  i_cfg_data,
    // Input pixel pair.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, lowest bits first: dst_blue, dst_green, dst_red,
    // src_blue, src_green, src_red, src_alpha (8 bits each).
    input  wire logic [55:0] s_axis_tdata,
    // Blended pixel.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata, lowest bits first: out_blue, out_green, out_red, out_alpha.
    output logic [31:0]      m_axis_tdata
);
    import pbfm_pkg::*;

    // Config registers, unguarded: change them only while no pixel is in flight.
    t_mode      r_mode;
    logic [8:0] r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ALPHA;
            r_weight <= W_ONE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_WEIGHT: r_weight <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Pipeline control: one valid flag per stage and a ready chain that
    // lets bubbles collapse, so the input keeps flowing while the output
    // waits as long as any stage is empty.
    t_ctl ctl;

    pbfm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (s_axis_tvalid),
        .i_out_rdy (m_axis_tready),
        .o_in_rdy  (s_axis_tready),
        .o_ctl     (ctl)
    );

    // Stage 1: capture the pixel together with the mode, the weight clamped
    // to 1.0 and the alpha-scaled weight w*sa (at most 65280) shared by the
    // three color channels.
    logic [8:0]  w_eff;
    logic [16:0] ws_full;

    t_mode       r_mode1;
    logic [8:0]  r_w1;
    logic [15:0] r_ws1;
    logic [7:0]  r_d1 [3];
    logic [7:0]  r_s1 [3];

    always_comb begin
        w_eff   = (r_weight > W_ONE) ? W_ONE : r_weight;
        ws_full = {8'd0, w_eff} * {9'd0, s_axis_tdata[55:48]};
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_mode1 <= r_mode;
            r_w1    <= w_eff;
            r_ws1   <= ws_full[15:0];
            for (int c = 0; c < 3; c++) begin
                r_d1[c] <= s_axis_tdata[8*c +: 8];
                r_s1[c] <= s_axis_tdata[24 + 8*c +: 8];
            end
        end
    end

    // Stages 2 to 5: one datapath lane per color channel. Each lane forms
    // its products, reduces them to a dividend, divides by 255 through a
    // reciprocal multiply (additive: saturating add) and registers the final byte.
    logic [7:0] ch [3];

    for (genvar c = 0; c < 3; c++) begin : g_lane
        pbfm_chan u_chan (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_mode (r_mode1),
            .i_w    (r_w1),
            .i_ws   (r_ws1),
            .i_d    (r_d1[c]),
            .i_s    (r_s1[c]),
            .o_ch   (ch[c])
        );
    end

    // The output alpha is always opaque.
    assign m_axis_tvalid = ctl.vld[NSTG-1];
    assign m_axis_tdata  = {CH_MAX, ch[2], ch[1], ch[0]};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

// Self-checking bench for the four-mode pixel blender.
// Every accepted input transaction is turned into an expected output pixel by a
// local model of the blend arithmetic. That pixel is queued, and each output
// transaction is compared against the oldest queued pixel.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pbfm_pkg::*;

    // Input transaction layout. The last member lands in the lowest bits, so the
    // struct maps directly onto s_axis_tdata.
    typedef struct packed {
        logic [7:0] src_alpha;
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
    } pixel_pair_t;

    // Output transaction layout, which matches m_axis_tdata in the same way.
    typedef struct packed {
        logic [7:0] out_alpha;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } blended_px_t;

    localparam int IDLE_PCT       = 7;
    localparam int PHASE_PIXELS   = 150;
    localparam int RANDOM_PHASES  = 11;

    // All block inputs start at known values before the first clock edge.
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_idx     = 1'b0;
    logic [8:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata, lowest bits first: dst_blue, dst_green, dst_red,
    // src_blue, src_green, src_red, src_alpha.
    logic [55:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata, lowest bits first: out_blue, out_green, out_red, out_alpha.
    logic [31:0] m_axis_tdata;

    // The local copy of the configuration registers, kept at their reset values
    // until the bench writes them.
    t_mode      cur_mode   = MODE_ALPHA;
    logic [8:0] cur_weight = W_ONE;

    // Pixels that have been accepted and whose blended result has not yet come out.
    blended_px_t expected_pixels[$];
    int unsigned mismatch_count = 0;

    // When this flag is set, neither side idles. It is used for one long
    // full-rate stretch.
    bit steady = 1'b0;

    pixel_blend_four_mode uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A correct run takes well under half a millisecond, even with every stall.
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Blend of one color channel. The weight has already been clamped to 1.0.
    // All products fit comfortably in 32 bits.
    function automatic logic [7:0] blend_channel_value(t_mode mode, int unsigned w,
                                                       logic [7:0] d, logic [7:0] s,
                                                       logic [7:0] sa);
        int unsigned du, su, ws, r;
        du = d;
        su = s;
        r  = 0;
        case (mode)
            MODE_ALPHA: begin
                // The source coverage w*sa runs from 0 to 65280, which is full cover.
                ws = w * int'(sa);
                r  = (du * (ALPHA_DEN - ws) + su * ws) / ALPHA_DEN;
            end
            MODE_ADD: begin
                r = du + ((su * w) >> 8);
                if (r > CH_MAX) begin
                    r = CH_MAX;
                end
            end
            MODE_MUL: begin
                r = (du * su) / CH_MAX;
            end
            MODE_SCREEN: begin
                r = (SQ_MAX - (CH_MAX - du) * (CH_MAX - su)) / CH_MAX;
            end
            default: begin
                r = 0;
            end
        endcase
        return r[7:0];
    endfunction

    // The result the blender should give for one input pair under the current
    // configuration. A weight register above 1.0 counts as exactly 1.0.
    function automatic blended_px_t blended_pixel(pixel_pair_t px);
        blended_px_t res;
        int unsigned w;
        w = (cur_weight > W_ONE) ? W_ONE : cur_weight;
        res.out_blue  = blend_channel_value(cur_mode, w, px.dst_blue,  px.src_blue,
                                            px.src_alpha);
        res.out_green = blend_channel_value(cur_mode, w, px.dst_green, px.src_green,
                                            px.src_alpha);
        res.out_red   = blend_channel_value(cur_mode, w, px.dst_red,   px.src_red,
                                            px.src_alpha);
        res.out_alpha = CH_MAX;
        return res;
    endfunction

    // Random channel bytes, biased toward 0 and 255 so that the saturation and
    // full-cover corners come up often.
    function automatic logic [7:0] random_channel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_pair_t random_pixel_pair();
        pixel_pair_t px;
        px.dst_blue  = random_channel();
        px.dst_green = random_channel();
        px.dst_red   = random_channel();
        px.src_blue  = random_channel();
        px.src_green = random_channel();
        px.src_red   = random_channel();
        px.src_alpha = random_channel();
        return px;
    endfunction

    // The weight for a random phase. It covers both ends, values above 1.0
    // (which must saturate) and the full legal range.
    function automatic logic [8:0] random_weight();
        case ($urandom_range(5))
            0:       return 9'd0;
            1:       return W_ONE;
            2:       return 9'd511;
            3:       return 9'($urandom_range(511, 257));
            default: return 9'($urandom_range(256));
        endcase
    endfunction

    // Offers one pixel pair and returns at the edge where it is accepted. It
    // queues the expected result at that edge. This task lowers tvalid only for
    // an idle cycle, and never in the step where it is raised again.
    task automatic send_pixel(pixel_pair_t px);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        expected_pixels.push_back(blended_pixel(px));
    endtask

    // Stops offering pixels, then waits until every queued result has come out.
    // Because every pixel gives exactly one result, an empty queue means the
    // pipeline is empty. The extra wait afterward still covers the full pipeline depth.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NSTG + 2) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back cycles once the block is idle.
    // The enable stays high across the two writes.
    task automatic set_config(t_mode mode, logic [8:0] weight);
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MODE;
        i_cfg_data <= {7'd0, mode};
        @(posedge i_clk);
        cur_mode   = mode;
        i_cfg_idx  <= CFG_WEIGHT;
        i_cfg_data <= weight;
        @(posedge i_clk);
        cur_weight = weight;
        i_cfg_we   <= 1'b0;
    endtask

    // With no register written, the block must use alpha mode at full weight.
    task automatic test_reset_defaults();
        repeat (3) send_pixel(random_pixel_pair());
    endtask

    // Corner cases for each mode: zero weight, full weight, a weight register
    // above 1.0, additive saturation, and both full and zero source alpha. The
    // second pixel has zero alpha, which must not change the result in the
    // three modes that ignore alpha.
    task automatic test_corner_pixels();
        t_mode       modes   [8] = '{MODE_ALPHA, MODE_ALPHA, MODE_ADD, MODE_ADD,
                                     MODE_ADD, MODE_MUL, MODE_SCREEN, MODE_SCREEN};
        logic [8:0]  weights [8] = '{9'd0, 9'd511, 9'd256, 9'd0,
                                     9'd300, 9'd256, 9'd256, 9'd0};
        pixel_pair_t full_cover;
        pixel_pair_t no_cover;
        full_cover = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd128, 8'd255, 8'd0};
        no_cover   = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        for (int i = 0; i < 8; i++) begin
            set_config(modes[i], weights[i]);
            send_pixel(full_cover);
            send_pixel(no_cover);
        end
    endtask

    // Random pixels under a series of settings. Each mode gets several phases,
    // and each phase draws a fresh weight. The block drains fully before each
    // new setting, so the sender also has to wait on the receiver.
    task automatic test_random_blends();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_config(t_mode'(ph % 4), random_weight());
            repeat (PHASE_PIXELS) send_pixel(random_pixel_pair());
        end
    endtask

    // A long burst with neither side idling, which drives one pixel per clock.
    task automatic test_full_rate_burst();
        set_config(t_mode'($urandom_range(3)), random_weight());
        steady = 1'b1;
        repeat (PHASE_PIXELS) send_pixel(random_pixel_pair());
        steady = 1'b0;
    endtask

    task automatic compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Output side. Each output transaction is checked against the oldest
    // expectation, and tready then gets its next random value. Signals are
    // sampled at the edge itself, which gives their settled values from before
    // the edge.
    always @(posedge i_clk) begin
        blended_px_t got;
        blended_px_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_pixels.size() == 0) begin
                $error("unexpected output transaction: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("out_blue",  want.out_blue,  got.out_blue);
                compare_field("out_green", want.out_green, got.out_green);
                compare_field("out_red",   want.out_red,   got.out_red);
                compare_field("out_alpha", want.out_alpha, got.out_alpha);
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_corner_pixels();
        test_random_blends();
        test_full_rate_burst();

        // Let everything drain; the wait afterward gives the block time to show
        // any extra output transaction.
        drain_pipeline();
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== pixel_blend_four_mode.f =====
+incdir+rtl
rtl/pbfm_pkg.sv
rtl/pbfm_ctrl.sv
rtl/pbfm_chan.sv
rtl/pixel_blend_four_mode.sv
tb/testbench.sv
